@@ sv/tsct_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and codes for the Taylor sine/cosine/tangent unit.
// No dependencies.
package tsct_pkg;

   localparam int MAX_SERIES_ORDER = 31;
   localparam int RESULT_FRAC_BITS = 30;
   localparam int WORK_BITS        = 60;
   localparam int WORD_W           = 64;
   localparam int NUM_CELLS        = MAX_SERIES_ORDER / 2;

   localparam int ANGLE_W  = 26;
   localparam int RESULT_W = 32;
   localparam int MAG_W    = RESULT_W - 1;
   localparam int THRESH_W = 31;
   localparam int TAN_FRAC = 16;
   localparam int QUO_W    = 32;

   // constant divider: chunked long division with reciprocal estimate
   localparam int CHUNK_W   = 16;
   localparam int CHUNKS    = WORD_W / CHUNK_W;
   localparam int DVS_W     = $clog2(MAX_SERIES_ORDER * (MAX_SERIES_ORDER - 1) + 1);
   localparam int RCP_W     = 32;
   localparam int CDIV_LAT  = 2 * CHUNKS;
   localparam int MUL_LAT   = 2;

   typedef enum logic [1:0] {
      SPEC_NONE,
      SPEC_HALF,
      SPEC_QPOS,
      SPEC_QNEG
   } spec_type;

   typedef struct packed {
      logic     neg;
      spec_type spec;
   } side_type;

   typedef struct packed {
      logic [WORD_W-1:0] x2;
      logic [WORD_W-1:0] sterm;
      logic [WORD_W-1:0] cterm;
      logic [WORD_W-1:0] ssum;
      logic [WORD_W-1:0] csum;
   } series_type;

   typedef struct packed {
      logic [MAG_W-1:0]    rem;
      logic [MAG_W-1:0]    dvs;
      logic [QUO_W-1:0]    nlo;
      logic [QUO_W-1:0]    quo;
      logic                ovf;
      logic                neg;
      logic                undef;
      logic [RESULT_W-1:0] sine;
      logic [RESULT_W-1:0] cosine;
   } div_type;

endpackage

@@ sv/tsct_mul.sv @@
`timescale 1ns / 1ps
// Two-stage 64x64 unsigned multiply, product shifted right by WORK_BITS, truncated.
// Depends on tsct_pkg.
module tsct_mul (
   input  logic                          clock,
   input  logic                          en,
   input  logic [tsct_pkg::WORD_W-1:0]   a,
   input  logic [tsct_pkg::WORD_W-1:0]   b,
   output logic [tsct_pkg::WORD_W-1:0]   p
);
   import tsct_pkg::*;

   localparam int HALF_W = WORD_W / 2;
   localparam int FULL_W = 2 * WORD_W;

   logic [WORD_W-1:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [WORD_W-1:0] ll_in, lh_in, hl_in, hh_in;
   logic [FULL_W-1:0] sum;
   logic [WORD_W-1:0] p_ff, p_in;

   assign ll_in = WORD_W'(a[HALF_W-1:0])      * WORD_W'(b[HALF_W-1:0]);
   assign lh_in = WORD_W'(a[HALF_W-1:0])      * WORD_W'(b[WORD_W-1:HALF_W]);
   assign hl_in = WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[HALF_W-1:0]);
   assign hh_in = WORD_W'(a[WORD_W-1:HALF_W]) * WORD_W'(b[WORD_W-1:HALF_W]);

   assign sum = {hh_ff, {WORD_W{1'b0}}}
              + {{HALF_W{1'b0}}, lh_ff, {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, hl_ff, {HALF_W{1'b0}}}
              + {{WORD_W{1'b0}}, ll_ff};
   assign p_in = sum[WORK_BITS+WORD_W-1:WORK_BITS];

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

@@ sv/tsct_cdiv.sv @@
`timescale 1ns / 1ps
// Pipelined division of a 64-bit word by a small constant, one chunk per two stages.
// Depends on tsct_pkg.
module tsct_cdiv (
   input  logic                          clock,
   input  logic                          en,
   input  logic [tsct_pkg::WORD_W-1:0]   num,
   input  logic [tsct_pkg::DVS_W-1:0]    dvs,
   input  logic [tsct_pkg::RCP_W-1:0]    rcp,
   output logic [tsct_pkg::WORD_W-1:0]   quo
);
   import tsct_pkg::*;

   localparam int V_W = DVS_W + CHUNK_W;
   localparam int P_W = V_W + RCP_W;

   logic [V_W-1:0]    a_v_ff   [CHUNKS];
   logic [P_W-1:0]    a_p_ff   [CHUNKS];
   logic [WORD_W-1:0] a_num_ff [CHUNKS];
   logic [WORD_W-1:0] a_quo_ff [CHUNKS];
   logic [DVS_W-1:0]  b_rem_ff [CHUNKS];
   logic [WORD_W-1:0] b_num_ff [CHUNKS];
   logic [WORD_W-1:0] b_quo_ff [CHUNKS];

   for (genvar j = 0; j < CHUNKS; j++) begin : g_chunk
      logic [DVS_W-1:0]   rem_src;
      logic [WORD_W-1:0]  num_src;
      logic [WORD_W-1:0]  quo_src;
      logic [V_W-1:0]     v_in;
      logic [P_W-1:0]     p_in;
      logic [CHUNK_W-1:0] qe;
      logic [CHUNK_W-1:0] q_in;
      logic [V_W-1:0]     r;
      logic [V_W-1:0]     r_fix;

      if (j == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = num;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = b_rem_ff[j-1];
         assign num_src = b_num_ff[j-1];
         assign quo_src = b_quo_ff[j-1];
      end

      assign v_in = {rem_src, num_src[WORD_W-1-j*CHUNK_W -: CHUNK_W]};
      assign p_in = P_W'(v_in) * P_W'(rcp);

      always_comb begin
         qe    = a_p_ff[j][RCP_W +: CHUNK_W];
         r     = a_v_ff[j] - V_W'(qe) * V_W'(dvs);
         q_in  = qe;
         r_fix = r;
         if (r >= V_W'(dvs)) begin
            q_in  = qe + 1'b1;
            r_fix = r - V_W'(dvs);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            a_v_ff[j]   <= v_in;
            a_p_ff[j]   <= p_in;
            a_num_ff[j] <= num_src;
            a_quo_ff[j] <= quo_src;
            b_rem_ff[j] <= r_fix[DVS_W-1:0];
            b_num_ff[j] <= a_num_ff[j];
            b_quo_ff[j] <= {a_quo_ff[j][WORD_W-CHUNK_W-1:0], q_in};
         end
      end
   end

   assign quo = b_quo_ff[CHUNKS-1];

endmodule

@@ sv/tsct_front.sv @@
`timescale 1ns / 1ps
// Front end: angle reduction into (-180, 180], degrees to Q60 radians, x squared.
// Depends on tsct_pkg and tsct_mul.
module tsct_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [tsct_pkg::ANGLE_W-1:0] angle,
   output logic                                out_valid,
   output tsct_pkg::series_type                out_data,
   output tsct_pkg::side_type                  out_side
);
   import tsct_pkg::*;

   localparam int A_W     = ANGLE_W + 1;
   localparam int ANG_FRAC = 16;
   localparam int MAG_IN_W = ANGLE_W - 2;
   localparam int HALF_W  = WORD_W / 2;
   localparam int PROD_W  = MAG_IN_W + HALF_W;
   localparam int SUM_W   = PROD_W + HALF_W;
   localparam logic signed [A_W-1:0] FULL_TURN    = A_W'(360 << ANG_FRAC);
   localparam logic signed [A_W-1:0] HALF_TURN    = A_W'(180 << ANG_FRAC);
   localparam logic signed [A_W-1:0] QUARTER_TURN = A_W'(90 << ANG_FRAC);
   localparam logic [WORD_W-1:0] PI_Q60     = 64'h3243F6A8885A308D;
   localparam logic [WORD_W-1:0] DEG_TO_RAD = PI_Q60 / 64'd180;
   localparam logic [WORD_W-1:0] ONE_Q60    = WORD_W'(1) << WORK_BITS;

   logic signed [A_W-1:0] a, r1, r2, r_abs;
   logic [MAG_IN_W-1:0]   mag_in;
   side_type              side_in;

   logic                  f0_valid_ff, f1_valid_ff, f2_valid_ff, f3_valid_ff, f4_valid_ff;
   logic [MAG_IN_W-1:0]   f0_mag_ff;
   side_type              f0_side_ff, f1_side_ff, f2_side_ff, f3_side_ff, f4_side_ff;
   logic [PROD_W-1:0]     f1_lo_ff, f1_hi_ff, f1_lo_in, f1_hi_in;
   logic [SUM_W-1:0]      x_sum;
   logic [WORD_W-1:0]     f2_x_ff, f2_x_in, f3_x_ff, f4_x_ff;
   logic [WORD_W-1:0]     x2;

   always_comb begin
      a  = A_W'(angle);
      r1 = a;
      if (a >= FULL_TURN) begin
         r1 = a - FULL_TURN;
      end else if (a <= -FULL_TURN) begin
         r1 = a + FULL_TURN;
      end
      r2 = r1;
      if (r1 > HALF_TURN) begin
         r2 = r1 - FULL_TURN;
      end else if (r1 <= -HALF_TURN) begin
         r2 = r1 + FULL_TURN;
      end
      r_abs        = r2[A_W-1] ? -r2 : r2;
      mag_in       = r_abs[MAG_IN_W-1:0];
      side_in.neg  = r2[A_W-1];
      if (r2 == HALF_TURN) begin
         side_in.spec = SPEC_HALF;
      end else if (r2 == QUARTER_TURN) begin
         side_in.spec = SPEC_QPOS;
      end else if (r2 == -QUARTER_TURN) begin
         side_in.spec = SPEC_QNEG;
      end else begin
         side_in.spec = SPEC_NONE;
      end
   end

   assign f1_lo_in = PROD_W'(f0_mag_ff) * PROD_W'(DEG_TO_RAD[HALF_W-1:0]);
   assign f1_hi_in = PROD_W'(f0_mag_ff) * PROD_W'(DEG_TO_RAD[WORD_W-1:HALF_W]);
   assign x_sum    = {f1_hi_ff, {HALF_W{1'b0}}} + SUM_W'(f1_lo_ff);
   assign f2_x_in  = x_sum[WORD_W+ANG_FRAC-1:ANG_FRAC];

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff <= 1'b0;
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
         f4_valid_ff <= 1'b0;
      end else if (en) begin
         f0_valid_ff <= in_valid;
         f1_valid_ff <= f0_valid_ff;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
         f4_valid_ff <= f3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f0_mag_ff  <= mag_in;
         f0_side_ff <= side_in;
         f1_lo_ff   <= f1_lo_in;
         f1_hi_ff   <= f1_hi_in;
         f1_side_ff <= f0_side_ff;
         f2_x_ff    <= f2_x_in;
         f2_side_ff <= f1_side_ff;
         f3_x_ff    <= f2_x_ff;
         f3_side_ff <= f2_side_ff;
         f4_x_ff    <= f3_x_ff;
         f4_side_ff <= f3_side_ff;
      end
   end

   tsct_mul u_sq (
      .clock (clock),
      .en    (en),
      .a     (f2_x_ff),
      .b     (f2_x_ff),
      .p     (x2)
   );

   assign out_valid      = f4_valid_ff;
   assign out_side       = f4_side_ff;
   assign out_data.x2    = x2;
   assign out_data.sterm = f4_x_ff;
   assign out_data.ssum  = f4_x_ff;
   assign out_data.cterm = ONE_Q60;
   assign out_data.csum  = ONE_Q60;

endmodule

@@ sv/tsct_cell.sv @@
`timescale 1ns / 1ps
// Series cell: next sine and cosine terms from x^2/((n-1)n), added to or subtracted from the running sums.
// Depends on tsct_pkg, tsct_cdiv and tsct_mul.
module tsct_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  tsct_pkg::series_type         in_data,
   input  tsct_pkg::side_type           in_side,
   input  logic [tsct_pkg::DVS_W-1:0]   cos_dvs,
   input  logic [tsct_pkg::RCP_W-1:0]   cos_rcp,
   input  logic [tsct_pkg::DVS_W-1:0]   sin_dvs,
   input  logic [tsct_pkg::RCP_W-1:0]   sin_rcp,
   input  logic                         sine_on,
   input  logic                         minus,
   output logic                         out_valid,
   output tsct_pkg::series_type         out_data,
   output tsct_pkg::side_type           out_side
);
   import tsct_pkg::*;

   localparam int DLY = CDIV_LAT + MUL_LAT;

   logic              dl_valid_ff [DLY];
   series_type        dl_data_ff  [DLY];
   side_type          dl_side_ff  [DLY];
   logic [WORD_W-1:0] qc, qs, pc, ps;
   logic              out_valid_ff;
   series_type        out_data_ff, out_data_in;
   side_type          out_side_ff;

   tsct_cdiv u_cdiv_cos (
      .clock (clock),
      .en    (en),
      .num   (in_data.x2),
      .dvs   (cos_dvs),
      .rcp   (cos_rcp),
      .quo   (qc)
   );

   tsct_cdiv u_cdiv_sin (
      .clock (clock),
      .en    (en),
      .num   (in_data.x2),
      .dvs   (sin_dvs),
      .rcp   (sin_rcp),
      .quo   (qs)
   );

   tsct_mul u_mul_cos (
      .clock (clock),
      .en    (en),
      .a     (dl_data_ff[CDIV_LAT-1].cterm),
      .b     (qc),
      .p     (pc)
   );

   tsct_mul u_mul_sin (
      .clock (clock),
      .en    (en),
      .a     (dl_data_ff[CDIV_LAT-1].sterm),
      .b     (qs),
      .p     (ps)
   );

   always_comb begin
      out_data_in       = dl_data_ff[DLY-1];
      out_data_in.cterm = pc;
      out_data_in.csum  = minus ? dl_data_ff[DLY-1].csum - pc : dl_data_ff[DLY-1].csum + pc;
      if (sine_on) begin
         out_data_in.sterm = ps;
         out_data_in.ssum  = minus ? dl_data_ff[DLY-1].ssum - ps
                                   : dl_data_ff[DLY-1].ssum + ps;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DLY; i++) begin
            dl_valid_ff[i] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (en) begin
         dl_valid_ff[0] <= in_valid;
         for (int i = 1; i < DLY; i++) begin
            dl_valid_ff[i] <= dl_valid_ff[i-1];
         end
         out_valid_ff <= dl_valid_ff[DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dl_data_ff[0] <= in_data;
         dl_side_ff[0] <= in_side;
         for (int i = 1; i < DLY; i++) begin
            dl_data_ff[i] <= dl_data_ff[i-1];
            dl_side_ff[i] <= dl_side_ff[i-1];
         end
         out_data_ff <= out_data_in;
         out_side_ff <= dl_side_ff[DLY-1];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_side  = out_side_ff;

endmodule

@@ sv/tsct_div_cell.sv @@
`timescale 1ns / 1ps
// Divider cell: one restoring step, one quotient bit of the tangent quotient.
// Depends on tsct_pkg.
module tsct_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  tsct_pkg::div_type in_data,
   output logic              out_valid,
   output tsct_pkg::div_type out_data
);
   import tsct_pkg::*;

   logic [MAG_W:0] trial;
   logic [MAG_W:0] dvs_ext;
   logic           out_valid_ff;
   div_type        out_data_ff, out_data_in;

   always_comb begin
      trial           = {in_data.rem, in_data.nlo[QUO_W-1]};
      dvs_ext         = {1'b0, in_data.dvs};
      out_data_in     = in_data;
      out_data_in.nlo = {in_data.nlo[QUO_W-2:0], 1'b0};
      if (trial >= dvs_ext) begin
         out_data_in.rem = MAG_W'(trial - dvs_ext);
         out_data_in.quo = {in_data.quo[QUO_W-2:0], 1'b1};
      end else begin
         out_data_in.rem = trial[MAG_W-1:0];
         out_data_in.quo = {in_data.quo[QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= out_data_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ sv/taylor_sine_cosine_tangent_unit.sv @@
`timescale 1ns / 1ps
// Top level: sine, cosine and tangent of an angle in degrees by Taylor series.
// Depends on tsct_pkg, tsct_front, tsct_cell and tsct_div_cell.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid/req_ready   | req_angle_degrees (Q9.16)
//   rsp     | out       | rsp_valid/rsp_ready   | sine, cosine (Q2.30), tangent (Q16.16), flag
//   csr     | in        | csr_valid/csr_ready   | csr_cosine_zero_threshold
//
// One item per cycle while the pipeline advances; an item passes the front end, the row of
// series cells, rounding, tangent setup, the 32 divider cells for tangent and the output register.
// The whole pipeline advances together; it holds only when the last stage has an item
// and the output register holds one not yet taken.
// Reset clears all valid bits and loads the threshold with 11.
module taylor_sine_cosine_tangent_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [tsct_pkg::ANGLE_W-1:0]    req_angle_degrees,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [tsct_pkg::RESULT_W-1:0]   rsp_sine_value,
   output logic signed [tsct_pkg::RESULT_W-1:0]   rsp_cosine_value,
   output logic signed [tsct_pkg::RESULT_W-1:0]   rsp_tangent_value,
   output logic                                   rsp_tangent_undefined,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tsct_pkg::THRESH_W-1:0]          csr_cosine_zero_threshold
);
   import tsct_pkg::*;

   localparam int SHIFT = WORK_BITS - RESULT_FRAC_BITS;
   localparam int N_W   = MAG_W + TAN_FRAC;
   localparam logic [WORD_W-1:0]   ROUND_HALF = WORD_W'(1) << (SHIFT - 1);
   localparam logic [WORD_W-1:0]   ONE_W      = WORD_W'(1) << RESULT_FRAC_BITS;
   localparam logic [RESULT_W-1:0] ONE_R      = RESULT_W'(ONE_W);
   localparam logic signed [RESULT_W-1:0] ONE_S = RESULT_W'(ONE_W);
   localparam logic [QUO_W-1:0]    TAN_MAX    = {1'b0, {(QUO_W-1){1'b1}}};
   localparam logic [QUO_W-1:0]    TAN_NEG    = {1'b1, {(QUO_W-1){1'b0}}};
   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(11);

   function automatic logic [RESULT_W-1:0] to_result(input logic [WORD_W-1:0] v);
      logic              neg;
      logic [WORD_W-1:0] mag;
      logic [WORD_W-1:0] m;
      neg = v[WORD_W-1];
      mag = neg ? -v : v;
      m   = (mag + ROUND_HALF) >> SHIFT;
      if (m > ONE_W) begin
         m = ONE_W;
      end
      return neg ? RESULT_W'(-m) : RESULT_W'(m);
   endfunction

   logic                en;
   logic                last_valid;
   logic [THRESH_W-1:0] thresh_ff;

   logic       cl_valid [NUM_CELLS+1];
   series_type cl_data  [NUM_CELLS+1];
   side_type   cl_side  [NUM_CELLS+1];

   logic                r1_valid_ff;
   logic [RESULT_W-1:0] r1_s_ff, r1_c_ff, r1_s_in, r1_c_in;
   logic [WORD_W-1:0]   ssum_eff;

   logic                r2_valid_ff;
   div_type             r2_data_ff, r2_data_in;
   logic [RESULT_W-1:0] s_abs, c_abs;
   logic [MAG_W-1:0]    sm, cm;
   logic [N_W-1:0]      n_full;

   logic    dv_valid [QUO_W+1];
   div_type dv_data  [QUO_W+1];

   logic                rsp_valid_ff, rsp_valid_in, load;
   logic [RESULT_W-1:0] sine_ff, cosine_ff, tan_ff, tan_in;
   logic                undef_ff;
   logic [QUO_W-1:0]    tan_mag;

   assign last_valid = dv_valid[QUO_W];
   assign en         = !last_valid || !rsp_valid_ff || rsp_ready;
   assign load       = last_valid && en;
   assign req_ready  = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RST;
      end else if (csr_valid) begin
         thresh_ff <= csr_cosine_zero_threshold;
      end
   end

   tsct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .angle     (req_angle_degrees),
      .out_valid (cl_valid[0]),
      .out_data  (cl_data[0]),
      .out_side  (cl_side[0])
   );

   for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
      localparam int unsigned COS_D = (2 * k - 1) * (2 * k);
      localparam int unsigned SIN_D = (2 * k) * (2 * k + 1);
      localparam logic [RCP_W-1:0] COS_R = RCP_W'((64'd1 << RCP_W) / COS_D);
      localparam logic [RCP_W-1:0] SIN_R = RCP_W'((64'd1 << RCP_W) / SIN_D);
      localparam logic SINE_ON = (2 * k + 1) <= MAX_SERIES_ORDER;
      localparam logic MINUS   = (k % 2) == 1;

      tsct_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (cl_valid[k-1]),
         .in_data   (cl_data[k-1]),
         .in_side   (cl_side[k-1]),
         .cos_dvs   (DVS_W'(COS_D)),
         .cos_rcp   (COS_R),
         .sin_dvs   (DVS_W'(SIN_D)),
         .sin_rcp   (SIN_R),
         .sine_on   (SINE_ON),
         .minus     (MINUS),
         .out_valid (cl_valid[k]),
         .out_data  (cl_data[k]),
         .out_side  (cl_side[k])
      );
   end

   // rounding and exact angles
   always_comb begin
      ssum_eff = cl_side[NUM_CELLS].neg ? -cl_data[NUM_CELLS].ssum : cl_data[NUM_CELLS].ssum;
      r1_s_in  = to_result(ssum_eff);
      r1_c_in  = to_result(cl_data[NUM_CELLS].csum);
      unique case (cl_side[NUM_CELLS].spec)
         SPEC_HALF: begin
            r1_s_in = '0;
            r1_c_in = -ONE_R;
         end
         SPEC_QPOS: begin
            r1_s_in = ONE_R;
            r1_c_in = '0;
         end
         SPEC_QNEG: begin
            r1_s_in = -ONE_R;
            r1_c_in = '0;
         end
         default: begin
         end
      endcase
   end

   // tangent setup: numerator |s| << 16 over |c|
   always_comb begin
      s_abs             = r1_s_ff[RESULT_W-1] ? -r1_s_ff : r1_s_ff;
      c_abs             = r1_c_ff[RESULT_W-1] ? -r1_c_ff : r1_c_ff;
      sm                = s_abs[MAG_W-1:0];
      cm                = c_abs[MAG_W-1:0];
      n_full            = {sm, {TAN_FRAC{1'b0}}};
      r2_data_in.rem    = MAG_W'(n_full[N_W-1:QUO_W]);
      r2_data_in.dvs    = cm;
      r2_data_in.nlo    = n_full[QUO_W-1:0];
      r2_data_in.quo    = '0;
      r2_data_in.ovf    = {{TAN_FRAC{1'b0}}, sm} >= {cm, {TAN_FRAC{1'b0}}};
      r2_data_in.neg    = r1_s_ff[RESULT_W-1] ^ r1_c_ff[RESULT_W-1];
      r2_data_in.undef  = (cm == '0) || (cm < thresh_ff);
      r2_data_in.sine   = r1_s_ff;
      r2_data_in.cosine = r1_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
      end else if (en) begin
         r1_valid_ff <= cl_valid[NUM_CELLS];
         r2_valid_ff <= r1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_s_ff    <= r1_s_in;
         r1_c_ff    <= r1_c_in;
         r2_data_ff <= r2_data_in;
      end
   end

   assign dv_valid[0] = r2_valid_ff;
   assign dv_data[0]  = r2_data_ff;

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      tsct_div_cell u_div_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (dv_valid[i]),
         .in_data   (dv_data[i]),
         .out_valid (dv_valid[i+1]),
         .out_data  (dv_data[i+1])
      );
   end

   // saturation and sign of tangent, zero when undefined
   always_comb begin
      tan_mag = dv_data[QUO_W].quo;
      if (dv_data[QUO_W].undef) begin
         tan_in = '0;
      end else if (dv_data[QUO_W].neg) begin
         if (dv_data[QUO_W].ovf || (dv_data[QUO_W].quo > TAN_NEG)) begin
            tan_mag = TAN_NEG;
         end
         tan_in = -tan_mag;
      end else begin
         if (dv_data[QUO_W].ovf || dv_data[QUO_W].quo[QUO_W-1]) begin
            tan_mag = TAN_MAX;
         end
         tan_in = tan_mag;
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sine_ff   <= dv_data[QUO_W].sine;
         cosine_ff <= dv_data[QUO_W].cosine;
         tan_ff    <= tan_in;
         undef_ff  <= dv_data[QUO_W].undef;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_sine_value        = sine_ff;
   assign rsp_cosine_value      = cosine_ff;
   assign rsp_tangent_value     = tan_ff;
   assign rsp_tangent_undefined = undef_ff;

   a_undef_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tangent_undefined |-> rsp_tangent_value == '0)
      else $error("tangent not zero while undefined");

   a_def_cos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tangent_undefined |-> rsp_cosine_value != '0)
      else $error("tangent defined with zero cosine");

   a_sine_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine_value <= ONE_S) && (rsp_sine_value >= -ONE_S))
      else $error("sine out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      last_valid && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("pipeline advanced into a full output register");

endmodule

@@ bench/taylor_sine_cosine_tangent_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for taylor_sine_cosine_tangent_unit: an angle item driver, a result
// monitor and a Taylor-series sine/cosine/tangent predictor. Depends on tsct_pkg.
module taylor_sine_cosine_tangent_unit_test;
   import tsct_pkg::*;

   localparam longint FULL_TURN    = 360 * 65536;
   localparam longint HALF_TURN    = 180 * 65536;
   localparam longint QUARTER_TURN = 90 * 65536;
   localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
   localparam int DRAIN_CYCLES     = 220;
   localparam int LONG_HOLD        = 2000;
   localparam int PHASE_ITEMS      = 270;

   typedef struct {
      logic signed [RESULT_W-1:0] sine;
      logic signed [RESULT_W-1:0] cosine;
      logic signed [RESULT_W-1:0] tangent;
      logic                       undef;
   } trig_result_type;

   logic                       clock = 0;
   logic                       reset = 1;
   logic                       req_valid = 0;
   logic                       req_ready;
   logic signed [ANGLE_W-1:0]  req_angle_degrees = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 0;
   logic signed [RESULT_W-1:0] rsp_sine_value;
   logic signed [RESULT_W-1:0] rsp_cosine_value;
   logic signed [RESULT_W-1:0] rsp_tangent_value;
   logic                       rsp_tangent_undefined;
   logic                       csr_valid = 0;
   logic                       csr_ready;
   logic [THRESH_W-1:0]        csr_cosine_zero_threshold = '0;

   logic signed [ANGLE_W-1:0]  pending_angles[$];
   trig_result_type            expected_trig[$];
   logic [63:0]                cos_threshold = 64'd11;
   int                         error_count = 0;
   bit                         long_hold_request = 0;

   taylor_sine_cosine_tangent_unit u_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_angle_degrees         (req_angle_degrees),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_sine_value            (rsp_sine_value),
      .rsp_cosine_value          (rsp_cosine_value),
      .rsp_tangent_value         (rsp_tangent_value),
      .rsp_tangent_undefined     (rsp_tangent_undefined),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_cosine_zero_threshold (csr_cosine_zero_threshold)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      p = p >> sh;
      return p[63:0];
   endfunction

   function automatic longint round_q30(longint v);
      logic [63:0] m;
      bit          neg;
      neg = v < 0;
      m = neg ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (WORK_BITS - RESULT_FRAC_BITS - 1))) >> (WORK_BITS - RESULT_FRAC_BITS);
      if (m > (64'd1 << RESULT_FRAC_BITS))
         m = 64'd1 << RESULT_FRAC_BITS;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic trig_result_type predict_trig(logic signed [ANGLE_W-1:0] ang);
      longint          r, s, c, t, ssum, csum;
      logic [63:0]     mag, x, x2, term, sm, cm, q;
      bit              minus, neg;
      trig_result_type res;
      r = longint'(ang) % FULL_TURN;
      t = 0;
      if (r > HALF_TURN)
         r -= FULL_TURN;
      if (r <= -HALF_TURN)
         r += FULL_TURN;
      if (r == HALF_TURN) begin
         s = 0;
         c = -(longint'(1) << RESULT_FRAC_BITS);
      end else if (r == QUARTER_TURN || r == -QUARTER_TURN) begin
         s = (r > 0) ? (longint'(1) << RESULT_FRAC_BITS) : -(longint'(1) << RESULT_FRAC_BITS);
         c = 0;
      end else begin
         mag = 64'(r < 0 ? -r : r);
         x = mul_q(mag, PI_Q60 / 64'd180, 16);
         x2 = mul_q(x, x, WORK_BITS);
         term = x;
         ssum = longint'(term);
         minus = 1;
         for (int n = 3; n <= MAX_SERIES_ORDER; n += 2) begin
            term = mul_q(term, x2 / 64'((n - 1) * n), WORK_BITS);
            ssum = minus ? ssum - longint'(term) : ssum + longint'(term);
            minus = !minus;
         end
         term = 64'd1 << WORK_BITS;
         csum = longint'(term);
         minus = 1;
         for (int n = 2; n <= MAX_SERIES_ORDER; n += 2) begin
            term = mul_q(term, x2 / 64'((n - 1) * n), WORK_BITS);
            csum = minus ? csum - longint'(term) : csum + longint'(term);
            minus = !minus;
         end
         if (r < 0)
            ssum = -ssum;
         s = round_q30(ssum);
         c = round_q30(csum);
      end
      sm = 64'(s < 0 ? -s : s);
      cm = 64'(c < 0 ? -c : c);
      res.undef = (cm == 0 || cm < cos_threshold);
      if (!res.undef) begin
         q = (sm << TAN_FRAC) / cm;
         neg = (s < 0) != (c < 0);
         if (neg) begin
            if (q > 64'h80000000)
               q = 64'h80000000;
            t = -longint'(q);
         end else begin
            if (q > 64'h7FFFFFFF)
               q = 64'h7FFFFFFF;
            t = longint'(q);
         end
      end
      res.sine = s[31:0];
      res.cosine = c[31:0];
      res.tangent = t[31:0];
      return res;
   endfunction

   function automatic int rand_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 60)
         return $urandom_range(1, 3);
      if (k < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
      error_count++;
   endtask

   // item driver
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_trig.push_back(predict_trig(req_angle_degrees));
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 0;
         end else if (pending_angles.size() > 0) begin
            req_valid <= 1;
            req_angle_degrees <= pending_angles.pop_front();
            send_gap = ($urandom_range(0, 99) < 70) ? 0 : rand_gap();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // result monitor
   int  recv_stall = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      trig_result_type want;
      if (reset) begin
         rsp_ready <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_trig.size() == 0) begin
               report_mismatch("unexpected item", 1, 0);
            end else begin
               want = expected_trig.pop_front();
               if (rsp_sine_value !== want.sine)
                  report_mismatch("sine", rsp_sine_value, want.sine);
               if (rsp_cosine_value !== want.cosine)
                  report_mismatch("cosine", rsp_cosine_value, want.cosine);
               if (rsp_tangent_value !== want.tangent)
                  report_mismatch("tangent", rsp_tangent_value, want.tangent);
               if (rsp_tangent_undefined !== want.undef)
                  report_mismatch("undefined", rsp_tangent_undefined, want.undef);
            end
         end
         if (long_hold_request && !long_hold_done) begin
            long_hold_done = 1;
            recv_stall = LONG_HOLD;
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 0;
         end else if ($urandom_range(0, 99) < 25) begin
            recv_stall = rand_gap();
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic drain();
      while (pending_angles.size() > 0 || req_valid || expected_trig.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_cosine_zero_threshold <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 0;
      cos_threshold = 64'(value);
   endtask

   function automatic logic signed [ANGLE_W-1:0] random_angle();
      longint k;
      if ($urandom_range(0, 99) < 65)
         return ANGLE_W'($urandom);
      k = longint'($urandom_range(0, 8)) - 4;
      return ANGLE_W'(k * QUARTER_TURN + longint'($urandom_range(0, 8)) - 4);
   endfunction

   task automatic random_phase(int count);
      repeat (count) pending_angles.push_back(random_angle());
   endtask

   initial begin
      logic [THRESH_W-1:0] settings[5];
      settings = '{31'd0, 31'h7FFFFFFF, 31'd1 << 30, 31'd1 << 20, 31'd0};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // quadrant points, wraparound, range limits and near-pole angles
      pending_angles.push_back(ANGLE_W'(0));
      pending_angles.push_back(ANGLE_W'(QUARTER_TURN));
      pending_angles.push_back(ANGLE_W'(-QUARTER_TURN));
      pending_angles.push_back(ANGLE_W'(HALF_TURN));
      pending_angles.push_back(ANGLE_W'(-HALF_TURN));
      pending_angles.push_back(ANGLE_W'(FULL_TURN));
      pending_angles.push_back(ANGLE_W'(-FULL_TURN));
      pending_angles.push_back(ANGLE_W'(3 * QUARTER_TURN));
      pending_angles.push_back(ANGLE_W'(-3 * QUARTER_TURN));
      pending_angles.push_back(ANGLE_W'(45 * 65536));
      pending_angles.push_back(ANGLE_W'(-45 * 65536));
      pending_angles.push_back(ANGLE_W'(30 * 65536));
      pending_angles.push_back(ANGLE_W'(135 * 65536));
      pending_angles.push_back(ANGLE_W'(QUARTER_TURN - 1));
      pending_angles.push_back(ANGLE_W'(QUARTER_TURN + 1));
      pending_angles.push_back(ANGLE_W'(-QUARTER_TURN + 1));
      pending_angles.push_back(ANGLE_W'(HALF_TURN - 1));
      pending_angles.push_back(ANGLE_W'(-HALF_TURN + 1));
      pending_angles.push_back(ANGLE_W'(1));
      pending_angles.push_back(ANGLE_W'(-1));
      pending_angles.push_back({1'b0, {(ANGLE_W-1){1'b1}}});
      pending_angles.push_back({1'b1, {(ANGLE_W-1){1'b0}}});
      pending_angles.push_back(ANGLE_W'(-1 * 32768));
      random_phase(PHASE_ITEMS);
      long_hold_request = 1;
      // sender pauses until every result is back, then resumes under the reset threshold
      while (pending_angles.size() > 0 || req_valid || expected_trig.size() > 0)
         @(posedge clock);
      random_phase(80);
      foreach (settings[i]) begin
         drain();
         write_threshold(i == 4 ? 31'($urandom_range(1, 1 << 26)) : settings[i]);
         random_phase(PHASE_ITEMS);
      end
      drain();
      if (error_count == 0)
         $display("taylor_sine_cosine_tangent_unit verification clean");
      else
         $display("taylor_sine_cosine_tangent_unit verification failed");
      $finish;
   end

   initial begin
      #4000000;
      $display("taylor_sine_cosine_tangent_unit verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/tsct_pkg.sv
sv/tsct_mul.sv
sv/tsct_cdiv.sv
sv/tsct_front.sv
sv/tsct_cell.sv
sv/tsct_div_cell.sv
sv/taylor_sine_cosine_tangent_unit.sv
bench/taylor_sine_cosine_tangent_unit_test.sv
